// ----- hw/rtl/sptu_pkg.sv -----
// Shared widths, constants and result type for the septet unpacker.
package sptu_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SEPTET_W = 7;
  localparam int unsigned ACC_W    = 2 * SEPTET_W;
  localparam int unsigned OFF_W    = 3;

  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SEPTET_W - 1);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              run_last;
    logic              block_end;
  } sptu_result_t;

endpackage

// ----- hw/rtl/septet_unpacker.sv -----
// Septet unpacker: 7-bit packed text to characters, up to two per packed byte.
// The first character of a request is registered and appears in the cycle after acceptance.
// Throughput: one request per cycle while out_ready stays high and each request
// yields one character; a request that yields two characters (every seventh packed byte,
// or a leftover flush) holds off the next one until its first character is taken.
// Reset: synchronous active-low rst_n empties the result buffer, clears the bit
// accumulator and offset, and makes the next byte the raw first byte of a block.
module septet_unpacker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sptu_pkg::CHAR_W-1:0] in_packed_byte,
  input  logic                        in_block_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sptu_pkg::CHAR_W-1:0] out_character,
  output logic                        out_run_last,
  output logic                        out_block_end
);
  import sptu_pkg::*;

  // unpacking state
  logic [SEPTET_W-1:0] acc_r, acc_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic                first_r, first_nxt;

  // two-entry result buffer, slot 0 is presented
  sptu_result_t slot0_r, slot0_nxt;
  sptu_result_t slot1_r, slot1_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  logic push, pop;
  logic [ACC_W-1:0]    sum;
  logic [SEPTET_W-1:0] hi;
  logic                seventh;
  logic                two;
  sptu_result_t        res0, res1;

  assign out_valid     = (cnt_r != 2'd0);
  assign pop           = out_valid && out_ready;
  assign in_ready      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign push          = in_valid && in_ready;
  assign out_character = slot0_r.character;
  assign out_run_last  = slot0_r.run_last;
  assign out_block_end = slot0_r.block_end;

  assign sum     = {{SEPTET_W{1'b0}}, acc_r} | ({{(ACC_W-CHAR_W){1'b0}}, in_packed_byte} << off_r);
  assign hi      = sum[ACC_W-1:SEPTET_W];
  assign seventh = (off_r == OFF_LAST);

  always_comb begin
    two       = 1'b0;
    acc_nxt   = acc_r;
    off_nxt   = off_r;
    first_nxt = first_r;
    res0      = '0;
    res1      = '0;
    if (first_r) begin
      res0.character = in_packed_byte;
      acc_nxt        = '0;
      off_nxt        = '0;
      first_nxt      = 1'b0;
    end else begin
      res0.character = {1'b0, sum[SEPTET_W-1:0]};
      res1.character = {1'b0, hi};
      if (seventh) begin
        two     = 1'b1;
        acc_nxt = '0;
        off_nxt = '0;
      end else begin
        // flush leftover bits only at block end and only when nonzero
        two     = in_block_last && (hi != '0);
        acc_nxt = hi;
        off_nxt = off_r + OFF_W'(1);
      end
    end
    res0.run_last  = !two;
    res0.block_end = !two && in_block_last;
    res1.run_last  = 1'b1;
    res1.block_end = in_block_last;
    if (in_block_last) begin
      acc_nxt   = '0;
      off_nxt   = '0;
      first_nxt = 1'b1;
    end
  end

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      // buffer is empty or draining its last entry this cycle
      slot0_nxt = res0;
      slot1_nxt = res1;
      cnt_nxt   = two ? 2'd2 : 2'd1;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      acc_r   <= '0;
      off_r   <= '0;
      first_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        acc_r   <= acc_nxt;
        off_r   <= off_nxt;
        first_r <= first_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r != OFF_W'(SEPTET_W))
    else $error("bit offset reached seven");

  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (acc_r == '0) && (off_r == '0))
    else $error("leftover bits while awaiting raw first byte");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !slot0_r.run_last && slot1_r.run_last)
    else $error("run_last misplaced within a result pair");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (cnt_r == 2'd1)) |-> pop)
    else $error("request accepted over a pending result");

endmodule

// ----- test/septet_unpacker_tb.sv -----
// Testbench for the septet unpacker: directed and random blocks against a built-in predictor.
module septet_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sptu_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_packed_byte = '0;
  logic                in_block_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   out_character;
  logic                out_run_last;
  logic                out_block_end;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned bytes_accepted = 0;

  // Predictor state, mirrors the unpacker registers
  logic [ACC_W-1:0] acc_bits = '0;
  logic [OFF_W-1:0] acc_offset = '0;
  logic             raw_pending = 1'b1;

  sptu_result_t expected_chars[$];
  sptu_result_t want_char;

  always #6 clk = ~clk;

  septet_unpacker DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packed_byte (in_packed_byte),
    .in_block_last  (in_block_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_run_last   (out_run_last),
    .out_block_end  (out_block_end)
  );

  function automatic void predict_chars(input logic [CHAR_W-1:0] b, input logic last);
    sptu_result_t chars[3];
    int           n;
    for (int i = 0; i < 3; i++) chars[i] = '0;
    n = 0;
    if (raw_pending) begin
      chars[0].character = b;
      n = 1;
      raw_pending = 1'b0;
      acc_bits = '0;
      acc_offset = '0;
    end else begin
      acc_bits = acc_bits | (ACC_W'(b) << acc_offset);
      chars[0].character = CHAR_W'(acc_bits[SEPTET_W-1:0]);
      n = 1;
      acc_bits = acc_bits >> SEPTET_W;
      // seventh packed byte completes a second septet
      if (acc_offset == OFF_LAST) begin
        chars[1].character = CHAR_W'(acc_bits[SEPTET_W-1:0]);
        n = 2;
        acc_bits = acc_bits >> SEPTET_W;
        acc_offset = '0;
      end else begin
        acc_offset = acc_offset + 1'b1;
      end
      // flush nonzero leftover bits at block end
      if (last && acc_bits != '0) begin
        chars[n].character = CHAR_W'(acc_bits[SEPTET_W-1:0]);
        n++;
      end
    end
    chars[n-1].run_last = 1'b1;
    if (last) begin
      chars[n-1].block_end = 1'b1;
      acc_bits = '0;
      acc_offset = '0;
      raw_pending = 1'b1;
    end
    for (int i = 0; i < n; i++) expected_chars.push_back(chars[i]);
  endfunction

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= 10)
      $display({"[%0t] %s: got char=%02h run_last=%0b block_end=%0b,",
                " want char=%02h run_last=%0b block_end=%0b"},
               $realtime, what, out_character, out_run_last, out_block_end,
               want_char.character, want_char.run_last, want_char.block_end);
  endtask

  // Result checker and receiver backpressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        want_char = '0;
        report_error("unexpected result");
      end else begin
        want_char = expected_chars.pop_front();
        if (out_character !== want_char.character || out_run_last !== want_char.run_last ||
            out_block_end !== want_char.block_end)
          report_error("mismatch");
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Call at a rising edge; returns at the edge where the request is accepted.
  task automatic send_request(input logic [CHAR_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_byte <= b;
    in_block_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_chars(b, last);
    bytes_accepted++;
  endtask

  task automatic test_single_byte_blocks();
    send_request(8'hff, 1'b1);
    send_request(8'h00, 1'b1);
  endtask

  // raw byte plus seven packed bytes: the last one yields two septets, no flush
  task automatic test_full_septet_group();
    send_request(8'h80, 1'b0);
    for (int i = 0; i < 7; i++) send_request(8'hff, i == 6);
  endtask

  task automatic test_leftover_handling();
    // zero leftover: no extra character
    send_request(8'h41, 1'b0);
    send_request(8'h00, 1'b1);
    // carried bits completed by the last byte: zero leftover, no extra character
    send_request(8'h7f, 1'b0);
    send_request(8'hff, 1'b0);
    send_request(8'h01, 1'b1);
  endtask

  task automatic send_random_block();
    int unsigned      len;
    int unsigned      pick;
    bit               clear_tail;
    logic [CHAR_W-1:0] b;
    pick = $urandom_range(9);
    if (pick < 3)       len = 1 + 7 * $urandom_range(1, 3);
    else if (pick < 4)  len = 1;
    else                len = $urandom_range(2, 24);
    clear_tail = ($urandom_range(2) == 0);
    for (int i = 0; i < len; i++) begin
      b = CHAR_W'($urandom);
      pick = $urandom_range(15);
      if (pick == 0) b = 8'h00;
      else if (pick == 1) b = 8'hff;
      // drop the bits that would be left over after the last byte
      if (clear_tail && i == len - 1 && len > 1) b = b & (8'hff >> (((i - 1) % 7) + 1));
      send_request(b, i == len - 1);
    end
  endtask

  task automatic test_random_blocks(input int unsigned n_bytes);
    int unsigned target;
    target = bytes_accepted + n_bytes;
    while (bytes_accepted < target) send_random_block();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 23;
    recv_stall_pct = 76;
    test_single_byte_blocks();
    test_full_septet_group();
    test_leftover_handling();
    test_random_blocks(510);

    send_idle_pct  = 76;
    recv_stall_pct = 23;
    test_random_blocks(510);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_blocks(510);

    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
